// ===== rtl/core/sdrs_pkg.sv =====
// shared types, widths and helpers for the strided dma row sequencer
`timescale 1ns / 1ps

package sdrs_pkg;

    localparam int MAIN_ADDR_BITS  = 24;
    localparam int LOCAL_ADDR_BITS = 12;
    localparam int LEN_BITS        = 12;
    localparam int BYTES_BITS      = LEN_BITS + 1;
    localparam int ROWS_BITS       = 8;
    localparam int CLK_BITS        = 16;
    // delay spans -1536 .. 65534, sign bit on top
    localparam int DELAY_BITS      = 18;
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS      = $clog2(Q_DEPTH + 1);

    localparam logic [LEN_BITS-1:0] IDLE_LENGTH = LEN_BITS'(12'hFF8);

    typedef enum logic {
        KIND_TICK    = 1'b0,
        KIND_REQUEST = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [CLK_BITS-1:0]        clocks;
        logic                       direction;
        logic                       region;
        logic [MAIN_ADDR_BITS-1:0]  main_address;
        logic [LOCAL_ADDR_BITS-1:0] local_address;
        logic [LEN_BITS-1:0]        row_length;
        logic [ROWS_BITS-1:0]       row_count;
        logic [LEN_BITS-1:0]        row_skip;
    } t_item;

    typedef struct packed {
        logic                       row_valid;
        logic                       row_direction;
        logic                       row_region;
        logic [MAIN_ADDR_BITS-1:0]  row_main_address;
        logic [LOCAL_ADDR_BITS-1:0] row_local_address;
        logic [BYTES_BITS-1:0]      row_bytes;
        logic                       row_last;
        logic                       engine_busy;
        logic                       pending_full;
        logic [LEN_BITS-1:0]        length_readback;
    } t_result;

    // queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // negative delay armed for one row: minus three times its count of eight-byte beats
    function automatic logic [DELAY_BITS-1:0] arm_delay(input logic [LEN_BITS-1:0] len);
        logic [DELAY_BITS-1:0] beats;
        logic [DELAY_BITS-1:0] cost;
        beats = DELAY_BITS'(len[LEN_BITS-1:3]) + DELAY_BITS'(1);
        cost  = beats + (beats << 1);
        return '0 - cost;
    endfunction

endpackage

// ===== rtl/core/sdrs_front.sv =====
// front end: takes input beats, masks request fields, pushes into the queue
`timescale 1ns / 1ps

module sdrs_front
    import sdrs_pkg::*;
(
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_kind,
    input  logic [CLK_BITS-1:0]        i_tick_clocks,
    input  logic                       i_req_direction,
    input  logic                       i_req_region,
    input  logic [MAIN_ADDR_BITS-1:0]  i_req_main_address,
    input  logic [LOCAL_ADDR_BITS-1:0] i_req_local_address,
    input  logic [LEN_BITS-1:0]        i_req_row_length,
    input  logic [ROWS_BITS-1:0]       i_req_row_count,
    input  logic [LEN_BITS-1:0]        i_req_row_skip,
    input  t_q_status                  i_q_status,
    output logic                       o_push,
    output t_item                      o_item
);

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // low three bits of addresses, length and skip are dropped
    always_comb begin
        o_item               = '0;
        o_item.kind          = i_kind ? KIND_REQUEST : KIND_TICK;
        o_item.clocks        = i_tick_clocks;
        o_item.direction     = i_req_direction;
        o_item.region        = i_req_region;
        o_item.main_address  = {i_req_main_address[MAIN_ADDR_BITS-1:3], 3'b000};
        o_item.local_address = {i_req_local_address[LOCAL_ADDR_BITS-1:3], 3'b000};
        o_item.row_length    = {i_req_row_length[LEN_BITS-1:3], 3'b000};
        o_item.row_count     = i_req_row_count;
        o_item.row_skip      = {i_req_row_skip[LEN_BITS-1:3], 3'b000};
    end

endmodule

// ===== rtl/core/sdrs_queue.sv =====
// short item queue between front and back end
`timescale 1ns / 1ps

module sdrs_queue
    import sdrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item                 r_slot [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count;

    assign o_item         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/sdrs_back.sv =====
// back end: slot state, delay counter, row issue and output register
`timescale 1ns / 1ps

module sdrs_back
    import sdrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item     i_item,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_result   o_result
);

    // active slot
    logic                       r_active,   n_active;
    logic                       r_a_dir,    n_a_dir;
    logic                       r_a_region, n_a_region;
    logic [MAIN_ADDR_BITS-1:0]  r_a_main,   n_a_main;
    logic [LOCAL_ADDR_BITS-1:0] r_a_local,  n_a_local;
    logic [LEN_BITS-1:0]        r_a_len,    n_a_len;
    logic [ROWS_BITS-1:0]       r_a_rows,   n_a_rows;
    logic [LEN_BITS-1:0]        r_a_skip,   n_a_skip;
    logic [DELAY_BITS-1:0]      r_delay,    n_delay;
    // waiting slot
    logic                       r_waiting,  n_waiting;
    t_item                      r_w,        n_w;
    // output register
    logic                       r_out_valid;
    t_result                    r_out,      n_out;

    logic                       w_row;
    logic                       w_last;
    logic [DELAY_BITS-1:0]      w_sum;
    logic [BYTES_BITS-1:0]      w_bytes;

    assign o_pop    = !i_q_status.empty && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign w_sum   = r_delay + DELAY_BITS'(i_item.clocks);
    assign w_bytes = BYTES_BITS'(r_a_len) + BYTES_BITS'(8);
    assign w_last  = (r_a_rows == '0);
    assign w_row   = (i_item.kind == KIND_TICK) && r_active && !w_sum[DELAY_BITS-1];

    always_comb begin
        n_active   = r_active;
        n_a_dir    = r_a_dir;
        n_a_region = r_a_region;
        n_a_main   = r_a_main;
        n_a_local  = r_a_local;
        n_a_len    = r_a_len;
        n_a_rows   = r_a_rows;
        n_a_skip   = r_a_skip;
        n_delay    = r_delay;
        n_waiting  = r_waiting;
        n_w        = r_w;
        n_out      = '0;

        unique case (i_item.kind)
            KIND_REQUEST: begin
                if (!r_active) begin
                    // idle engine takes the request straight through
                    n_active   = 1'b1;
                    n_a_dir    = i_item.direction;
                    n_a_region = i_item.region;
                    n_a_main   = i_item.main_address;
                    n_a_local  = i_item.local_address;
                    n_a_len    = i_item.row_length;
                    n_a_rows   = i_item.row_count;
                    n_a_skip   = i_item.row_skip;
                    n_delay    = arm_delay(i_item.row_length);
                    n_waiting  = 1'b0;
                end else begin
                    n_waiting  = 1'b1;
                end
                n_w = i_item;
            end
            KIND_TICK: begin
                if (r_active) begin
                    n_delay = w_sum;
                end
                if (w_row) begin
                    n_out.row_valid         = 1'b1;
                    n_out.row_direction     = r_a_dir;
                    n_out.row_region        = r_a_region;
                    n_out.row_main_address  = r_a_main;
                    n_out.row_local_address = r_a_local;
                    n_out.row_bytes         = w_bytes;
                    n_out.row_last          = w_last;
                    n_a_local = r_a_local + LOCAL_ADDR_BITS'(w_bytes);
                    if (!w_last) begin
                        n_a_rows = r_a_rows - 1'b1;
                        n_a_main = r_a_main + MAIN_ADDR_BITS'(w_bytes)
                                 + MAIN_ADDR_BITS'(r_a_skip);
                        n_delay  = arm_delay(r_a_len);
                    end else if (r_waiting) begin
                        // transfer ends, pending request starts at once
                        n_a_dir    = r_w.direction;
                        n_a_region = r_w.region;
                        n_a_main   = r_w.main_address;
                        n_a_local  = r_w.local_address;
                        n_a_len    = r_w.row_length;
                        n_a_rows   = r_w.row_count;
                        n_a_skip   = r_w.row_skip;
                        n_delay    = arm_delay(r_w.row_length);
                        n_waiting  = 1'b0;
                    end else begin
                        n_active = 1'b0;
                        n_a_len  = IDLE_LENGTH;
                        n_a_main = r_a_main + MAIN_ADDR_BITS'(w_bytes);
                    end
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase

        n_out.engine_busy     = n_active;
        n_out.pending_full    = n_waiting;
        n_out.length_readback = n_a_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_a_dir     <= 1'b0;
            r_a_region  <= 1'b0;
            r_a_main    <= '0;
            r_a_local   <= '0;
            r_a_len     <= IDLE_LENGTH;
            r_a_rows    <= '0;
            r_a_skip    <= '0;
            r_delay     <= '0;
            r_waiting   <= 1'b0;
            r_w         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active   <= n_active;
                r_a_dir    <= n_a_dir;
                r_a_region <= n_a_region;
                r_a_main   <= n_a_main;
                r_a_local  <= n_a_local;
                r_a_len    <= n_a_len;
                r_a_rows   <= n_a_rows;
                r_a_skip   <= n_a_skip;
                r_delay    <= n_delay;
                r_waiting  <= n_waiting;
                r_w        <= n_w;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_idle_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_a_len == IDLE_LENGTH))
        else $error("idle engine does not read back idle length");

    a_no_wait_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> !r_waiting)
        else $error("pending request left while engine idle");

    a_row_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.row_valid) |-> (r_out.row_bytes[2:0] == 3'b000 &&
        r_out.row_bytes != '0))
        else $error("row byte count misaligned");

    a_mid_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_row && !w_last) |=> r_active)
        else $error("engine went idle in the middle of a transfer");

    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.kind == KIND_REQUEST) |=> (r_active && r_out.engine_busy))
        else $error("request did not leave the engine busy");

endmodule

// ===== rtl/core/strided_dma_row_sequencer.sv =====
// top level of the strided dma row sequencer
`timescale 1ns / 1ps

//  channel  direction  handshake            payload
//  in       to block   i_valid / o_stall    i_kind, i_tick_clocks, i_req_*
//  out      from block o_valid / i_stall    o_row_*, o_engine_busy, o_pending_full,
//                                           o_length_readback
//
//  one result beat per input beat; one item per cycle sustained while i_stall is low;
//  each item passes the queue write, then the back-end update into the output register
//  the two-entry queue lets input beats land while the output register is stalled
//  o_stall rises only when the queue is full
//  reset is synchronous, active low; it clears both slots and the queue

module strided_dma_row_sequencer
    import sdrs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input beats
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_kind,
    input  logic [CLK_BITS-1:0]        i_tick_clocks,
    input  logic                       i_req_direction,
    input  logic                       i_req_region,
    input  logic [MAIN_ADDR_BITS-1:0]  i_req_main_address,
    input  logic [LOCAL_ADDR_BITS-1:0] i_req_local_address,
    input  logic [LEN_BITS-1:0]        i_req_row_length,
    input  logic [ROWS_BITS-1:0]       i_req_row_count,
    input  logic [LEN_BITS-1:0]        i_req_row_skip,
    // result beats
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_row_valid,
    output logic                       o_row_direction,
    output logic                       o_row_region,
    output logic [MAIN_ADDR_BITS-1:0]  o_row_main_address,
    output logic [LOCAL_ADDR_BITS-1:0] o_row_local_address,
    output logic [BYTES_BITS-1:0]      o_row_bytes,
    output logic                       o_row_last,
    output logic                       o_engine_busy,
    output logic                       o_pending_full,
    output logic [LEN_BITS-1:0]        o_length_readback
);

    t_q_status w_q_status;
    t_item     w_push_item;
    t_item     w_head_item;
    logic      w_push;
    logic      w_pop;
    t_result   w_result;

    // front end: field masking and kind decode
    sdrs_front u_front (
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_kind              (i_kind),
        .i_tick_clocks       (i_tick_clocks),
        .i_req_direction     (i_req_direction),
        .i_req_region        (i_req_region),
        .i_req_main_address  (i_req_main_address),
        .i_req_local_address (i_req_local_address),
        .i_req_row_length    (i_req_row_length),
        .i_req_row_count     (i_req_row_count),
        .i_req_row_skip      (i_req_row_skip),
        .i_q_status          (w_q_status),
        .o_push              (w_push),
        .o_item              (w_push_item)
    );

    // decoupling queue
    sdrs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    // back end: slot state, delay, row issue
    sdrs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_head_item),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (w_result)
    );

    assign o_row_valid         = w_result.row_valid;
    assign o_row_direction     = w_result.row_direction;
    assign o_row_region        = w_result.row_region;
    assign o_row_main_address  = w_result.row_main_address;
    assign o_row_local_address = w_result.row_local_address;
    assign o_row_bytes         = w_result.row_bytes;
    assign o_row_last          = w_result.row_last;
    assign o_engine_busy       = w_result.engine_busy;
    assign o_pending_full      = w_result.pending_full;
    assign o_length_readback   = w_result.length_readback;

endmodule
